// ===== rtl/core/alivr_pkg.sv =====
// Package for the adjacent line intersection / vanishing row block.
// Holds shared constants.
package alivr_pkg;
  localparam int CoordBitsDef   = 11;
  localparam int MaxSegmentsDef = 1024;
  localparam int PtBits    = 35;
  localparam int SumBits   = 21;
  localparam int CntBits   = 11;
  localparam int CfgBits   = 12;
  localparam int RowOutBits = 11;
  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;
endpackage

// ===== rtl/core/alivr_divider.sv =====
// Serial signed divider: restoring, one quotient bit per cycle, truncating toward zero.
// Depends on nothing but its parameters.
module alivr_divider #(
  parameter int NB = 64,
  parameter int DB = 44
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NB-1:0] num,
  input  logic signed [DB-1:0] den,
  output logic                 done,
  output logic signed [NB-1:0] quo
);
  localparam int CW = $clog2(NB + 1);
  logic [NB-1:0] q_r, q_nxt;
  logic [DB:0]   rem_r, rem_nxt;
  logic [DB-1:0] dv_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DB:0]   trial;
  logic [DB:0]   sh;

  always_comb begin
    sh = {rem_r[DB-1:0], q_r[NB-1]};
    trial = sh - {1'b0, dv_r};
    if (!trial[DB]) begin
      rem_nxt = trial;
      q_nxt = {q_r[NB-2:0], 1'b1};
    end else begin
      rem_nxt = sh;
      q_nxt = {q_r[NB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CW'(NB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      q_r <= num[NB-1] ? NB'(-num) : num;
      dv_r <= den[DB-1] ? DB'(-den) : den;
      neg_r <= num[NB-1] ^ den[DB-1];
      rem_r <= '0;
    end else if (busy_r) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? NB'(-q_r) : q_r;
endmodule

// ===== rtl/core/alivr_front.sv =====
// Front end: accepts segments, keeps the previous one and queues work words.
// Depends on nothing outside this module.
module alivr_front #(
  parameter int CB = 11
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic [CB-1:0]   in_start_col,
  input  logic [CB-1:0]   in_start_row,
  input  logic [CB-1:0]   in_end_col,
  input  logic [CB-1:0]   in_end_row,
  input  logic            in_frame_end,
  output logic            q_valid,
  input  logic            q_take,
  output logic [8*CB-1:0] q_seg,
  output logic            q_have,
  output logic            q_last
);
  localparam int WW = 8 * CB + 2;
  logic [4*CB-1:0] prev_r;
  logic            pres_r;
  logic [WW-1:0]   mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            acc;
  logic [WW-1:0]   wr;

  assign in_full = cnt_r == 2'd2;
  assign acc = in_push && !in_full;
  assign wr = {in_frame_end, pres_r, prev_r,
               in_start_col, in_start_row, in_end_col, in_end_row};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r <= 1'b0;
      prev_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (acc) begin
        prev_r <= {in_start_col, in_start_row, in_end_col, in_end_row};
        pres_r <= !in_frame_end;
        if (pres_r || in_frame_end) wp_r <= !wp_r;
      end
      if (q_valid && q_take) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(acc && (pres_r || in_frame_end)) - 2'(q_valid && q_take);
    end
    if (acc) mem_r[wp_r] <= wr;
  end

  assign q_valid = cnt_r != 2'd0;
  assign q_seg  = mem_r[rp_r][8*CB-1:0];
  assign q_have = mem_r[rp_r][WW-2];
  assign q_last = mem_r[rp_r][WW-1];
endmodule

// ===== rtl/core/alivr_back.sv =====
// Back end: intersects lines, divides, classifies, accumulates the mean row.
// Uses alivr_pkg and alivr_divider.
module alivr_back #(
  parameter int CB = 11
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_take,
  input  logic [8*CB-1:0] q_seg,
  input  logic q_have,
  input  logic q_last,
  input  logic [alivr_pkg::CfgBits-1:0] image_width,
  input  logic [alivr_pkg::CfgBits-1:0] image_height,
  output logic out_empty,
  input  logic out_pop,
  output logic out_point_valid,
  output logic signed [alivr_pkg::PtBits-1:0] out_point_col,
  output logic signed [alivr_pkg::PtBits-1:0] out_point_row,
  output logic out_point_inside,
  output logic out_vanish_valid,
  output logic [alivr_pkg::RowOutBits-1:0] out_vanish_row,
  output logic out_frame_done
);
  import alivr_pkg::*;
  localparam int EB = CB + 2;
  localparam int CC = 2 * CB + 2;
  localparam int XB = EB + CC + 2;
  localparam int WB = 2 * EB + 2;
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_P1 = 7'b0000010, S_P2 = 7'b0000100,
    S_DIV  = 7'b0001000, S_CHK = 7'b0010000, S_MEAN = 7'b0100000,
    S_OUT  = 7'b1000000
  } st_t;
  st_t st_r;
  logic signed [EB-1:0] ac_r, bc_r, ap_r, bp_r;
  logic signed [CC-1:0] cc_r, cp_r;
  logic signed [XB-1:0] wx_r, wy_r;
  logic signed [WB-1:0] w_r;
  logic have_r, last_r, inside_r;
  logic [SumBits-1:0] sum_r;
  logic [CntBits-1:0] cnt_r;
  logic signed [XB-1:0] px_r, py_r;
  logic dstart, ddx, ddy;
  logic signed [XB-1:0] qx, qy;
  logic signed [WB-1:0] dd;
  logic [CB-1:0] c0, r0, c1, r1, p0, q0, p1, q1;
  logic mean_go, mdone;
  logic signed [SumBits+1:0] mq;
  logic [SumBits:0] sumadd;
  logic ins, ins_add;
  logic [SumBits-1:0] sum_upd;
  logic [CntBits-1:0] cnt_upd;

  assign {p0, q0, p1, q1, c0, r0, c1, r1} = q_seg;
  assign q_take = st_r == S_IDLE && q_valid && out_empty;
  assign dd = (w_r == '0) ? WB'(1) : w_r;
  assign dstart = st_r == S_P2 && have_r;

  alivr_divider #(.NB(XB), .DB(WB)) u_dx (
    .clk, .rst_n, .start(dstart), .num(wx_r), .den(dd),
    .done(ddx), .quo(qx));
  alivr_divider #(.NB(XB), .DB(WB)) u_dy (
    .clk, .rst_n, .start(dstart), .num(wy_r), .den(dd),
    .done(ddy), .quo(qy));
  alivr_divider #(.NB(SumBits + 2), .DB(CntBits + 1)) u_mean (
    .clk, .rst_n, .start(mean_go), .num({2'b00, sum_upd}), .den({1'b0, cnt_upd}),
    .done(mdone), .quo(mq));

  assign ins = !px_r[XB-1] && !py_r[XB-1]
    && px_r < $signed({1'b0, XB'(image_width)})
    && py_r < $signed({1'b0, XB'(image_height)});
  assign ins_add = have_r && ins;
  assign sumadd = {1'b0, sum_r} + (SumBits+1)'(py_r[CfgBits-1:0]);
  assign sum_upd = ins_add ? (sumadd[SumBits] ? '1 : sumadd[SumBits-1:0]) : sum_r;
  assign cnt_upd = (ins_add && cnt_r != '1) ? cnt_r + 1'b1 : cnt_r;
  assign mean_go = st_r == S_CHK && last_r && cnt_upd != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_empty <= 1'b1;
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      if (!out_empty && out_pop) out_empty <= 1'b1;
      case (st_r)
        S_IDLE: if (q_take) st_r <= S_P1;
        S_P1: st_r <= S_P2;
        S_P2: st_r <= have_r ? S_DIV : S_CHK;
        S_DIV: if (ddx && ddy) st_r <= S_CHK;
        S_CHK: begin
          sum_r <= sum_upd;
          cnt_r <= cnt_upd;
          st_r <= mean_go ? S_MEAN : S_OUT;
        end
        S_MEAN: if (mdone) st_r <= S_OUT;
        S_OUT: begin
          out_empty <= 1'b0;
          if (last_r) begin
            sum_r <= '0;
            cnt_r <= '0;
          end
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
    case (st_r)
      S_IDLE: if (q_take) begin
        have_r <= q_have;
        last_r <= q_last;
        ac_r <= EB'(r0) - EB'(r1);
        bc_r <= EB'(c1) - EB'(c0);
        cc_r <= CC'(c0 * r1) - CC'(c1 * r0);
        ap_r <= EB'(q0) - EB'(q1);
        bp_r <= EB'(p1) - EB'(p0);
        cp_r <= CC'(p0 * q1) - CC'(p1 * q0);
      end
      S_P1: begin
        wx_r <= XB'(bp_r * cc_r) - XB'(cp_r * bc_r);
        wy_r <= XB'(cp_r * ac_r) - XB'(ap_r * cc_r);
        w_r  <= WB'(ap_r * bc_r) - WB'(bp_r * ac_r);
      end
      S_P2: begin
        px_r <= '0;
        py_r <= '0;
      end
      S_DIV: if (ddx && ddy) begin
        px_r <= qx;
        py_r <= qy;
      end
      S_CHK: inside_r <= ins_add;
      S_OUT: begin
        out_point_valid <= have_r;
        out_point_col <= PtBits'(px_r);
        out_point_row <= PtBits'(py_r);
        out_point_inside <= inside_r;
        out_frame_done <= last_r;
        out_vanish_valid <= last_r && cnt_r != '0;
        out_vanish_row <= (last_r && cnt_r != '0)
          ? ((mq > (SumBits+2)'(2047)) ? '1 : RowOutBits'(mq)) : '0;
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/core/adjacent_line_intersection_vanish_row.sv =====
// Adjacent line intersection and vanishing row estimator, top level.
// From accept, a work word passes S_P1 and S_P2, then the serial dividers in S_DIV when it
// has an intersection, then S_CHK, S_MEAN when the frame's last segment also forms the mean,
// and S_OUT, which writes the result word. One segment is in the back end at a time: the next
// is taken only once the back end is idle and the previous result word has been popped.
// Synchronous active-low reset clears frame state and loads 640 x 480.
module adjacent_line_intersection_vanish_row #(
  parameter int COORD_BITS   = alivr_pkg::CoordBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  logic [COORD_BITS-1:0] in_start_col,
  input  logic [COORD_BITS-1:0] in_start_row,
  input  logic [COORD_BITS-1:0] in_end_col,
  input  logic [COORD_BITS-1:0] in_end_row,
  input  logic in_frame_end,
  output logic out_empty,
  input  logic out_pop,
  output logic out_point_valid,
  output logic signed [alivr_pkg::PtBits-1:0] out_point_col,
  output logic signed [alivr_pkg::PtBits-1:0] out_point_row,
  output logic out_point_inside,
  output logic out_vanish_valid,
  output logic [alivr_pkg::RowOutBits-1:0] out_vanish_row,
  output logic out_frame_done,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import alivr_pkg::*;
  logic [CfgBits-1:0] width_r, height_r;
  logic q_valid, q_take, q_have, q_last;
  logic [8*COORD_BITS-1:0] q_seg;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= CfgBits'(640);
      height_r <= CfgBits'(480);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == RegWidth) width_r <= cfg_pwdata[CfgBits-1:0];
      else height_r <= cfg_pwdata[CfgBits-1:0];
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == RegHeight) cfg_prdata[CfgBits-1:0] = height_r;
    else cfg_prdata[CfgBits-1:0] = width_r;
  end

  alivr_front #(.CB(COORD_BITS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_start_col, .in_start_row,
    .in_end_col, .in_end_row, .in_frame_end,
    .q_valid, .q_take, .q_seg, .q_have, .q_last);

  alivr_back #(.CB(COORD_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_seg, .q_have, .q_last,
    .image_width(width_r), .image_height(height_r),
    .out_empty, .out_pop, .out_point_valid, .out_point_col, .out_point_row,
    .out_point_inside, .out_vanish_valid, .out_vanish_row, .out_frame_done);
endmodule

// ===== sim/tb_adjacent_line_intersection_vanish_row.sv =====
// Testbench for the adjacent line intersection / vanishing row block.
// Drives segments through the push/full queue, predicts each result word and
// checks it field by field; depends on alivr_pkg and the top level only.
`timescale 1ns / 1ps
module tb_adjacent_line_intersection_vanish_row;
  import alivr_pkg::*;

  localparam int CB = CoordBitsDef;
  localparam int LAT = 2 * CB + 45;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic                           point_valid;
    logic signed [PtBits-1:0]       point_col;
    logic signed [PtBits-1:0]       point_row;
    logic                           point_inside;
    logic                           vanish_valid;
    logic [RowOutBits-1:0]          vanish_row;
    logic                           frame_done;
  } point_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [CB-1:0] in_start_col = '0, in_start_row = '0, in_end_col = '0, in_end_row = '0;
  logic in_frame_end = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_point_valid, out_point_inside, out_vanish_valid, out_frame_done;
  logic signed [PtBits-1:0] out_point_col, out_point_row;
  logic [RowOutBits-1:0] out_vanish_row;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  adjacent_line_intersection_vanish_row u_top (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  longint unsigned img_w = 640, img_h = 480;
  longint prev_seg[4];
  bit prev_here = 0;
  longint unsigned row_acc = 0, inside_cnt = 0;
  point_word_t expected_words[$];

  int errors = 0, words_seen = 0, items_sent = 0, frames_done = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0;
  longint cycles = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch word %0d %s: got %0d want %0d", words_seen, what, got, want);
  endtask

  function automatic void predict_segment(input longint unsigned sc, sr, ec, er, input bit last);
    longint cur[4];
    longint ac, bc, cc, ap, bp, cp, wx, wy, w, px, py;
    bit have = 0, ins = 0;
    point_word_t wd;
    cur[0] = sc; cur[1] = sr; cur[2] = ec; cur[3] = er;
    px = 0; py = 0;
    if (prev_here) begin
      ac = cur[1] - cur[3]; bc = cur[2] - cur[0]; cc = cur[0] * cur[3] - cur[2] * cur[1];
      ap = prev_seg[1] - prev_seg[3]; bp = prev_seg[2] - prev_seg[0];
      cp = prev_seg[0] * prev_seg[3] - prev_seg[2] * prev_seg[1];
      wx = bp * cc - cp * bc; wy = cp * ac - ap * cc; w = ap * bc - bp * ac;
      if (w == 0) w = 1;
      px = wx / w; py = wy / w;
      have = 1;
      ins = px >= 0 && py >= 0 && px < longint'(img_w) && py < longint'(img_h);
      if (ins) begin
        row_acc += py;
        if (row_acc > 64'd2097151) row_acc = 2097151;
        if (inside_cnt < 2047) inside_cnt++;
      end
    end
    for (int k = 0; k < 4; k++) prev_seg[k] = cur[k];
    prev_here = 1;
    if (!have && !last) return;
    wd = '0;
    wd.point_valid = have;
    wd.point_col = px[PtBits-1:0];
    wd.point_row = py[PtBits-1:0];
    wd.point_inside = ins;
    wd.frame_done = last;
    if (last) begin
      if (inside_cnt != 0) begin
        longint unsigned m = row_acc / inside_cnt;
        if (m > 2047) m = 2047;
        wd.vanish_valid = 1;
        wd.vanish_row = m[RowOutBits-1:0];
      end
      for (int k = 0; k < 4; k++) prev_seg[k] = 0;
      prev_here = 0; row_acc = 0; inside_cnt = 0;
    end
    expected_words = {expected_words, wd};
  endfunction

  task automatic send_segment(input int sc, sr, ec, er, input bit last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_start_col <= CB'(sc); in_start_row <= CB'(sr);
    in_end_col <= CB'(ec); in_end_row <= CB'(er);
    in_frame_end <= last; in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_segment(sc, sr, ec, er, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (LAT + 10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input int unsigned val);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= addr; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(negedge clk);
    if (addr == 3'd0) img_w = val & 12'hfff; else img_h = val & 12'hfff;
  endtask

  task automatic set_image(input int unsigned w, input int unsigned h);
    wait_drained();
    write_reg(3'd0, w);
    write_reg(3'd4, h);
  endtask

  // result checker
  always @(posedge clk) begin
    point_word_t want;
    if (rst_n && out_pop && !out_empty) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = expected_words.pop_front();
        if (out_point_valid !== want.point_valid)
          report_mismatch("point_valid", out_point_valid, want.point_valid);
        if (out_point_col !== want.point_col)
          report_mismatch("point_col", out_point_col, want.point_col);
        if (out_point_row !== want.point_row)
          report_mismatch("point_row", out_point_row, want.point_row);
        if (out_point_inside !== want.point_inside)
          report_mismatch("point_inside", out_point_inside, want.point_inside);
        if (out_vanish_valid !== want.vanish_valid)
          report_mismatch("vanish_valid", out_vanish_valid, want.vanish_valid);
        if (out_vanish_row !== want.vanish_row)
          report_mismatch("vanish_row", out_vanish_row, want.vanish_row);
        if (out_frame_done !== want.frame_done)
          report_mismatch("frame_done", out_frame_done, want.frame_done);
        if (want.frame_done) frames_done++;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off) out_pop <= 1'b0;
    else out_pop <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** adjacent_line_intersection_vanish_row: FAILED **");
      $finish;
    end
  end

  function automatic int rand_coord();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return 2047;
    if (r < 6) return $urandom_range(700);
    return $urandom_range(2047);
  endfunction

  task automatic send_random_frame(input int max_len);
    int len;
    len = $urandom_range(max_len, 1);
    for (int i = 0; i < len; i++)
      send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(), i == len - 1);
  endtask

  task automatic test_directed();
    send_segment(5, 5, 100, 100, 1);
    send_segment(0, 0, 2047, 2047, 0);
    send_segment(0, 2047, 2047, 0, 1);
    send_segment(10, 10, 20, 20, 0);
    send_segment(30, 30, 40, 40, 0);
    send_segment(7, 7, 7, 7, 0);
    send_segment(2047, 2047, 2047, 2047, 1);
    send_segment(0, 0, 2047, 1, 0);
    send_segment(0, 1, 2047, 0, 0);
    send_segment(2047, 0, 0, 2047, 0);
    send_segment(0, 2047, 1, 0, 0);
    send_segment(100, 0, 100, 2047, 0);
    send_segment(0, 300, 2047, 300, 1);
    send_segment(0, 479, 640, 479, 0);
    send_segment(639, 0, 639, 900, 1);
    send_segment(0, 480, 900, 480, 0);
    send_segment(640, 0, 640, 900, 1);
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    int target;
    send_idle_pct = s_pct; recv_stall_pct = r_pct;
    target = items_sent + count;
    while (items_sent < target) send_random_frame($urandom_range(9) == 0 ? 40 : 6);
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 12; i++)
        send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(), i == 11);
    join
    wait_drained();
  endtask

  task automatic test_long_frame();
    // many inside points so counts and sums climb
    for (int i = 0; i < 60; i++)
      send_segment($urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                   $urandom_range(2047), i == 59);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    set_image(1, 1);
    test_random(150, 0, 0);
    set_image(2048, 2048);
    test_directed();
    test_random(400, 71, 0);
    set_image(4095, 4095);
    test_long_frame();
    test_random(200, 0, 71);
    set_image(0, 0);
    test_random(100, 28, 28);
    set_image(1024, 2047);
    test_backpressure();
    test_random(400, 28, 28);
    set_image(640, 480);
    test_random(600, 0, 0);
    wait_drained();
    $display("sent %0d segments, checked %0d words across %0d frames", items_sent,
             words_seen, frames_done);
    $display("image sizes from 0 to 4095, idle and stall phases, full-queue back-pressure");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("** adjacent_line_intersection_vanish_row: PASSED **");
    end else begin
      $display("%0d mismatches, %0d words outstanding", errors, expected_words.size());
      $display("** adjacent_line_intersection_vanish_row: FAILED **");
    end
    $finish;
  end
endmodule
